// File: src/occupancy_grid_ray_update_top_assert.svh
// Assertion macros used by the checker file.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_TOP_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OGRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define OGRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/ogru_pkg.sv
// Package with shared constants and types of the occupancy grid ray update block.
package ogru_pkg;
  localparam int CoordBits = 8;
  localparam int MapSide = 256;
  localparam int AddrBits = 16;
  localparam int CountBits = 16;
  localparam int WalkBits = 9;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;

  localparam logic [1:0] ModeTrace = 2'd0;
  localparam logic [1:0] ModeRead = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  localparam logic [1:0] CellUnknown = 2'd0;
  localparam logic [1:0] CellFree = 2'd1;
  localparam logic [1:0] CellOccupied = 2'd2;

  localparam logic [CfgIdxBits-1:0] CfgMinScans = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRatioNum = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgRatioDen = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgNearSkip = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic end_updated;
    logic [1:0] cell_state;
    logic dynamic_flag;
    logic [CountBits-1:0] hit_total;
    logic [CountBits-1:0] scan_total;
    logic [WalkBits-1:0] cells_walked;
  } rsp_t;

  typedef struct packed {
    logic [1:0] state;
    logic dyn;
    logic [CountBits-1:0] hits;
    logic [CountBits-1:0] scans;
  } cell_t;

  typedef struct packed {
    logic [15:0] min_scans;
    logic [7:0] ratio_num;
    logic [7:0] ratio_den;
    logic [3:0] near_skip;
  } cfg_t;

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c);
    bump = (&c) ? c : c + 1'b1;
  endfunction
endpackage

// File: src/ogru_if.sv
// Valid/ready channel interfaces for requests and results.
interface ogru_req_if (input logic clk);
  logic valid;
  logic ready;
  ogru_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ogru_rsp_if (input logic clk);
  logic valid;
  logic ready;
  ogru_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/ogru_cell_ram.sv
// Cell store memory with a clearing pass, one write and one registered read port.
module ogru_cell_ram (
  input  logic clk,
  input  logic rst_n,
  input  logic clear,
  output logic busy,
  input  logic rd_en,
  input  logic [ogru_pkg::AddrBits-1:0] rd_addr,
  output ogru_pkg::cell_t rd_data,
  input  logic wr_en,
  input  logic [ogru_pkg::AddrBits-1:0] wr_addr,
  input  ogru_pkg::cell_t wr_data
);
  localparam int Depth = 1 << ogru_pkg::AddrBits;
  localparam int W = $bits(ogru_pkg::cell_t);

  logic [W-1:0] mem [Depth];
  logic [W-1:0] q_r;
  logic [ogru_pkg::AddrBits-1:0] sweep_r;
  logic sweeping_r;

  // After reset and after each clear, every entry is written to zero in turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweeping_r <= 1'b1;
      sweep_r <= '0;
    end else if (clear) begin
      sweeping_r <= 1'b1;
      sweep_r <= '0;
    end else if (sweeping_r) begin
      sweep_r <= sweep_r + 1'b1;
      if (&sweep_r) begin
        sweeping_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping_r) begin
      mem[sweep_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;
  assign busy = sweeping_r;
endmodule

// File: src/ogru_engine.sv
// Ray walk sequencer doing read-modify-write of cells in the store.
module ogru_engine (
  input  logic clk,
  input  logic rst_n,
  input  ogru_pkg::cfg_t cfg,
  ogru_req_if.sink req,
  ogru_rsp_if.source rsp
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMod = 3'd2;
  localparam logic [2:0] StMul = 3'd3;
  localparam logic [2:0] StRep = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  localparam int CB = ogru_pkg::CoordBits;

  logic [2:0] st_r, st_nxt;
  ogru_pkg::req_t q_r;
  logic [CB-1:0] x_r, y_r;
  logic signed [CB+2:0] err_r;
  logic [CB:0] dx_r, dy_r;
  logic sx_r, sy_r;
  logic [ogru_pkg::WalkBits-1:0] step_r;
  logic touch_r, upd_r;
  ogru_pkg::cell_t cell_r;
  logic [23:0] lhs_r, rhs_r;
  ogru_pkg::rsp_t out_r;
  logic outv_r;

  logic rd_en, wr_en, clr, ram_busy;
  logic [ogru_pkg::AddrBits-1:0] rd_addr, wr_addr;
  ogru_pkg::cell_t rd_data, wr_data;

  ogru_cell_ram u_ram (
    .clk, .rst_n, .clear(clr), .busy(ram_busy), .rd_en, .rd_addr, .rd_data,
    .wr_en, .wr_addr, .wr_data
  );

  logic is_end;
  logic signed [CB+3:0] e2;
  assign is_end = (x_r == q_r.end_x) && (y_r == q_r.end_y);
  assign e2 = {err_r, 1'b0};

  assign req.ready = (st_r == StIdle) && !outv_r && !ram_busy;
  assign rsp.valid = outv_r;
  assign rsp.data = out_r;
  assign rd_addr = {y_r, x_r};
  assign wr_addr = {y_r, x_r};
  assign rd_en = (st_r == StRead);
  assign clr = (st_r == StIdle) && req.valid && req.ready
             && (req.data.mode == ogru_pkg::ModeClear);

  logic [ogru_pkg::CountBits-1:0] nscan, nhit;
  assign nscan = ogru_pkg::bump(rd_data.scans);
  assign nhit = ogru_pkg::bump(rd_data.hits);

  always_comb begin
    wr_en = 1'b0;
    wr_data = cell_r;
    if (st_r == StMod && touch_r && !is_end) begin
      wr_en = 1'b1;
      wr_data = rd_data;
      wr_data.scans = nscan;
      wr_data.state = ogru_pkg::CellFree;
    end else if (st_r == StMul) begin
      wr_en = 1'b1;
      if (cell_r.scans > cfg.min_scans) begin
        wr_data.dyn = lhs_r < rhs_r;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      StIdle: if (req.valid && req.ready) begin
        if (req.data.mode == ogru_pkg::ModeTrace) st_nxt = StRead;
        else if (req.data.mode == ogru_pkg::ModeRead) st_nxt = StRead;
        else st_nxt = StOut;
      end
      StRead: st_nxt = StMod;
      StMod: begin
        if (q_r.mode != ogru_pkg::ModeTrace) st_nxt = StOut;
        else if (is_end) st_nxt = touch_r ? StMul : StOut;
        else st_nxt = StRead;
      end
      StMul: st_nxt = StOut;
      StRep: st_nxt = StOut;
      StOut: st_nxt = StIdle;
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (rsp.valid && rsp.ready) outv_r <= 1'b0;
      if (st_r == StOut) outv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      StIdle: begin
        if (req.valid && req.ready) begin
          q_r <= req.data;
          out_r <= '0;
          upd_r <= 1'b0;
          step_r <= '0;
          if (req.data.mode == ogru_pkg::ModeRead) begin
            x_r <= req.data.end_x;
            y_r <= req.data.end_y;
            touch_r <= 1'b0;
          end else begin
            x_r <= req.data.start_x;
            y_r <= req.data.start_y;
            touch_r <= (cfg.near_skip == 4'd0);
          end
          dx_r <= (req.data.end_x > req.data.start_x)
                ? {1'b0, req.data.end_x - req.data.start_x}
                : {1'b0, req.data.start_x - req.data.end_x};
          dy_r <= (req.data.end_y > req.data.start_y)
                ? {1'b0, req.data.end_y - req.data.start_y}
                : {1'b0, req.data.start_y - req.data.end_y};
          sx_r <= req.data.start_x < req.data.end_x;
          sy_r <= req.data.start_y < req.data.end_y;
          err_r <= $signed({2'b0, (req.data.end_x > req.data.start_x)
                  ? req.data.end_x - req.data.start_x
                  : req.data.start_x - req.data.end_x})
                 - $signed({2'b0, (req.data.end_y > req.data.start_y)
                  ? req.data.end_y - req.data.start_y
                  : req.data.start_y - req.data.end_y});
        end
      end
      StRead: ;
      StMod: begin
        step_r <= step_r + 1'b1;
        if (q_r.mode != ogru_pkg::ModeTrace) begin
          cell_r <= rd_data;
        end else if (is_end) begin
          cell_r <= rd_data;
          if (touch_r) begin
            cell_r.scans <= nscan;
            cell_r.hits <= nhit;
            cell_r.state <= ogru_pkg::CellOccupied;
            lhs_r <= nhit * cfg.ratio_den;
            rhs_r <= nscan * cfg.ratio_num;
            upd_r <= 1'b1;
          end
        end else begin
          touch_r <= ({5'b0, step_r} + 14'd1) >= {10'b0, cfg.near_skip};
          if (e2 > -$signed({3'b0, dy_r}) && e2 < $signed({3'b0, dx_r})) begin
            err_r <= err_r - $signed({2'b0, dy_r}) + $signed({2'b0, dx_r});
          end else if (e2 > -$signed({3'b0, dy_r})) begin
            err_r <= err_r - $signed({2'b0, dy_r});
          end else if (e2 < $signed({3'b0, dx_r})) begin
            err_r <= err_r + $signed({2'b0, dx_r});
          end
          if (e2 > -$signed({3'b0, dy_r})) x_r <= sx_r ? x_r + 1'b1 : x_r - 1'b1;
          if (e2 < $signed({3'b0, dx_r})) y_r <= sy_r ? y_r + 1'b1 : y_r - 1'b1;
        end
      end
      StMul: if (cell_r.scans > cfg.min_scans) cell_r.dyn <= lhs_r < rhs_r;
      StRep: ;
      StOut: begin
        if (q_r.mode == ogru_pkg::ModeTrace || q_r.mode == ogru_pkg::ModeRead) begin
          out_r.end_updated <= upd_r;
          out_r.cell_state <= cell_r.state;
          out_r.dynamic_flag <= cell_r.dyn;
          out_r.hit_total <= cell_r.hits;
          out_r.scan_total <= cell_r.scans;
          out_r.cells_walked <= (q_r.mode == ogru_pkg::ModeTrace) ? step_r : '0;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: src/occupancy_grid_ray_update_top.sv
// Top level of the occupancy grid ray update block.
// Requests arrive on the in_ channel (valid/ready) carrying a mode and a
// start and end cell; one result per request leaves on the out_ channel.
// A trace walks the Bresenham line over the 256 by 256 grid cell by cell:
// a read of the cell store, then the modified write-back.
// A new request is taken only after the result has gone (outv_r cleared)
// and the store is not busy.
// Registers min_scans, ratio_num, ratio_den and near_skip are written on the
// cfg_ port by index; the user must write them only while the block is idle,
// as the block itself does not enforce this.
// After reset, and after each clear, a pass over all 65536 entries zeroes
// the store; no request is taken until it has finished.
// When the receiver stalls, the result stays in the output register and
// no new request is taken until it has gone.
module occupancy_grid_ray_update_top (
  input  logic clk,
  input  logic rst_n,
  ogru_req_if.sink in_req,
  ogru_rsp_if.source out_rsp,
  input  logic cfg_we,
  input  logic [ogru_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [ogru_pkg::CfgDataBits-1:0] cfg_wdata
);
  ogru_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_scans <= 16'd10;
      cfg_r.ratio_num <= 8'd2;
      cfg_r.ratio_den <= 8'd5;
      cfg_r.near_skip <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogru_pkg::CfgMinScans: cfg_r.min_scans <= cfg_wdata;
        ogru_pkg::CfgRatioNum: cfg_r.ratio_num <= cfg_wdata[7:0];
        ogru_pkg::CfgRatioDen: cfg_r.ratio_den <= cfg_wdata[7:0];
        ogru_pkg::CfgNearSkip: cfg_r.near_skip <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  ogru_engine u_engine (.clk, .rst_n, .cfg(cfg_r), .req(in_req), .rsp(out_rsp));
endmodule

// File: src/ogru_checker.sv
// Port-level checker for the ray update block and its bind.
`include "occupancy_grid_ray_update_top_assert.svh"
module ogru_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [8:0] out_walked,
  input logic out_updated,
  input logic [1:0] out_state
);
  `OGRU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `OGRU_ASSERT_IMP(a_no_take, clk, rst_n, out_valid, !in_ready, "request taken while result waits")
  `OGRU_ASSERT_NEXT(a_gap, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
  `OGRU_ASSERT_IMP(a_upd, clk, rst_n, out_valid && out_updated, out_state == ogru_pkg::CellOccupied && out_walked != 9'd0, "update without occupied cell")
endmodule

bind occupancy_grid_ray_update_top ogru_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_walked(out_rsp.data.cells_walked),
  .out_updated(out_rsp.data.end_updated),
  .out_state(out_rsp.data.cell_state)
);
